FILE: design/assert_macros.svh
// Assertion macros used by the top level of the accumulator machine.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that holds at every clock edge outside reset.
`define ACC16_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("acc16 assertion failed");
// A consequence that holds in the same cycle as its cause.
`define ACC16_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acc16 implication failed");
// A consequence that holds in the cycle after its cause.
`define ACC16_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acc16 next-cycle implication failed");
`else
`define ACC16_ASSERT(lbl, clk, rst_n, prop)
`define ACC16_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ACC16_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/acc16_pkg.sv
// Shared types and constants of the accumulator machine.
// Depends on nothing; used by the interfaces, the ALU and the top level.
package acc16_pkg;

    // Default sizes of the design.
    localparam int MEM_WORDS_DEF = 4096;
    localparam int WORD_BITS_DEF = 16;

    // Fixed field widths of the item channels.
    localparam int IO_BITS      = 16;
    localparam int MODE_BITS    = 2;
    localparam int ERR_BITS     = 2;
    localparam int ADDR_BITS    = 12;
    localparam int OPERAND_BITS = 12;
    localparam int OPC_BITS     = 4;

    // Item modes.
    typedef enum logic [MODE_BITS-1:0] {
        MODE_EXEC  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    // Instruction opcodes.
    typedef enum logic [OPC_BITS-1:0] {
        OP_LDA = 4'h0,
        OP_STA = 4'h1,
        OP_ADD = 4'h2,
        OP_MUL = 4'h3,
        OP_DIV = 4'h4,
        OP_MOD = 4'h5,
        OP_SEA = 4'hF
    } t_opcode;

    // Error codes reported with each result item.
    typedef enum logic [ERR_BITS-1:0] {
        ERR_NONE  = 2'd0,
        ERR_DIV0  = 2'd1,
        ERR_MOD0  = 2'd2,
        ERR_BADOP = 2'd3
    } t_err;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_MUL,
        ALU_DIV,
        ALU_MOD
    } t_alu_op;

    // Start request to the arithmetic unit.
    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

FILE: design/acc16_in_if.sv
// Input channel of the accumulator machine: valid, ready and one item.
// Depends on acc16_pkg for the field widths.
interface acc16_in_if;
    logic                               valid;
    logic                               ready;
    logic [acc16_pkg::MODE_BITS-1:0]    mode;
    logic [acc16_pkg::IO_BITS-1:0]      instr_word;
    logic [acc16_pkg::ADDR_BITS-1:0]    host_address;
    logic [acc16_pkg::IO_BITS-1:0]      host_data;

    modport source (output valid, mode, instr_word, host_address, host_data, input ready);
    modport sink   (input valid, mode, instr_word, host_address, host_data, output ready);
endinterface

FILE: design/acc16_out_if.sv
// Result channel of the accumulator machine: valid, ready and one item.
// Depends on acc16_pkg for the field widths.
interface acc16_out_if;
    logic                               valid;
    logic                               ready;
    logic [acc16_pkg::IO_BITS-1:0]      accumulator;
    logic [acc16_pkg::IO_BITS-1:0]      program_counter;
    logic [acc16_pkg::IO_BITS-1:0]      read_word;
    logic [acc16_pkg::ERR_BITS-1:0]     error_code;

    modport source (output valid, accumulator, program_counter, read_word, error_code,
                    input ready);
    modport sink   (input valid, accumulator, program_counter, read_word, error_code,
                    output ready);
endinterface

FILE: design/accumulator_cpu16_execute.sv
// Top level of the accumulator machine. Depends on acc16_pkg, acc16_in_if,
// acc16_out_if, acc16_ram, acc16_alu and assert_macros.svh.
//
// Use: each item on i_in executes one instruction (mode 0), writes a data
// memory word from the host (mode 1) or reads one for the host (mode 2).
// Every item yields exactly one result item on o_out with the accumulator,
// the program counter, the word read and an error code.
// After reset the block sweeps the data memory to zero, one word a cycle,
// through every word; i_in.ready stays low until the sweep is done.
// One item is worked on at a time. After acceptance an item passes S_EXEC
// and then S_DONE, which loads the output register, for SEA, STA, host
// write, the unused mode, invalid opcodes and a zero divisor. LDA and host
// read pass S_LOAD between the two (unless the address lies beyond memory),
// and ADD, MUL (12-step shift-add) and DIV and MOD (one quotient bit a cycle
// in the shared unit) pass S_ALU; at 16-bit words DIV and MOD are the
// slowest items. The block is ready again when the result is registered,
// so a new item is taken only once the last result is registered.
// A result waits in the output register while o_out.ready is low; the next
// item is still accepted and held until the output register is free.
`include "assert_macros.svh"

module accumulator_cpu16_execute #(
    parameter int MEM_WORDS = acc16_pkg::MEM_WORDS_DEF,
    parameter int WORD_BITS = acc16_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acc16_in_if.sink    i_in,
    acc16_out_if.source o_out
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int IO = acc16_pkg::IO_BITS;
    localparam int OB = acc16_pkg::OPERAND_BITS;
    localparam int AB = acc16_pkg::ADDR_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_ALU,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [AW-1:0]                 r_clr;
    logic [WORD_BITS-1:0]          r_acc;
    logic [WORD_BITS-1:0]          r_alu;
    logic [IO-1:0]                 r_pc;
    logic [IO-1:0]                 r_instr;
    acc16_pkg::t_mode              r_mode;
    logic [AB-1:0]                 r_addr;
    logic [IO-1:0]                 r_hdata;
    logic [IO-1:0]                 r_rd;
    acc16_pkg::t_err               r_err;
    logic                          r_out_valid;
    logic [IO-1:0]                 r_out_acc;
    logic [IO-1:0]                 r_out_pc;
    logic [IO-1:0]                 r_out_rd;
    acc16_pkg::t_err               r_out_err;

    acc16_pkg::t_opcode            opc;
    logic [OB-1:0]                 operand;
    logic [AB-1:0]                 mem_addr;
    logic                          in_range;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [WORD_BITS-1:0]          ram_wdata;
    logic [WORD_BITS-1:0]          ram_rdata;
    acc16_pkg::t_alu_req           alu_req;
    logic                          alu_done;
    logic [WORD_BITS-1:0]          alu_result;

    // Instruction fields and the memory address of the current item.
    always_comb begin
        opc      = acc16_pkg::t_opcode'(r_instr[IO-1 -: acc16_pkg::OPC_BITS]);
        operand  = r_instr[OB-1:0];
        mem_addr = (r_mode == acc16_pkg::MODE_EXEC) ? AB'(operand) : r_addr;
        in_range = ({1'b0, mem_addr} < (AB+1)'(MEM_WORDS));
    end

    // Memory write port: the clearing sweep, a store or a host write.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = mem_addr[AW-1:0];
        ram_wdata = WORD_BITS'(r_hdata);
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else if (r_state == S_EXEC && in_range) begin
            if (r_mode == acc16_pkg::MODE_EXEC && opc == acc16_pkg::OP_STA) begin
                ram_we    = 1'b1;
                ram_wdata = r_acc;
            end else if (r_mode == acc16_pkg::MODE_WRITE) begin
                ram_we    = 1'b1;
            end
        end
    end

    // Start of the arithmetic unit; division by zero never reaches it.
    always_comb begin
        alu_req.start = 1'b0;
        alu_req.op    = acc16_pkg::ALU_ADD;
        if (r_state == S_EXEC && r_mode == acc16_pkg::MODE_EXEC) begin
            case (opc)
                acc16_pkg::OP_ADD: begin
                    alu_req.start = 1'b1;
                    alu_req.op    = acc16_pkg::ALU_ADD;
                end
                acc16_pkg::OP_MUL: begin
                    alu_req.start = 1'b1;
                    alu_req.op    = acc16_pkg::ALU_MUL;
                end
                acc16_pkg::OP_DIV: begin
                    alu_req.start = (operand != '0);
                    alu_req.op    = acc16_pkg::ALU_DIV;
                end
                acc16_pkg::OP_MOD: begin
                    alu_req.start = (operand != '0);
                    alu_req.op    = acc16_pkg::ALU_MOD;
                end
                default: begin
                    alu_req.start = 1'b0;
                end
            endcase
        end
    end

    acc16_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (mem_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    acc16_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (r_acc),
        .i_b      (operand),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    // Sequencer: machine state, item registers and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_acc       <= '0;
            r_alu       <= '0;
            r_pc        <= '0;
            r_instr     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A taken result frees the output register unless a new one loads.
            if (o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(MEM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_mode  <= acc16_pkg::t_mode'(i_in.mode);
                        r_addr  <= i_in.host_address;
                        r_hdata <= i_in.host_data;
                        if (i_in.mode == acc16_pkg::MODE_EXEC) begin
                            r_instr <= i_in.instr_word;
                        end
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_err   <= acc16_pkg::ERR_NONE;
                    r_rd    <= '0;
                    r_state <= S_DONE;
                    unique case (r_mode)
                        acc16_pkg::MODE_EXEC: begin
                            r_pc <= r_pc + 1'b1;
                            unique case (opc) inside
                                acc16_pkg::OP_LDA: begin
                                    if (in_range) begin
                                        r_state <= S_LOAD;
                                    end else begin
                                        r_acc <= '0;
                                    end
                                end
                                acc16_pkg::OP_SEA: begin
                                    r_acc <= WORD_BITS'(operand);
                                end
                                acc16_pkg::OP_ADD, acc16_pkg::OP_MUL: begin
                                    r_state <= S_ALU;
                                end
                                acc16_pkg::OP_DIV, acc16_pkg::OP_MOD: begin
                                    if (operand == '0) begin
                                        r_acc <= r_alu;
                                        r_err <= (opc == acc16_pkg::OP_DIV)
                                                 ? acc16_pkg::ERR_DIV0
                                                 : acc16_pkg::ERR_MOD0;
                                    end else begin
                                        r_state <= S_ALU;
                                    end
                                end
                                acc16_pkg::OP_STA: begin
                                    r_state <= S_DONE;
                                end
                                default: begin
                                    r_err <= acc16_pkg::ERR_BADOP;
                                end
                            endcase
                        end
                        acc16_pkg::MODE_READ: begin
                            if (in_range) begin
                                r_state <= S_LOAD;
                            end
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_LOAD: begin
                    if (r_mode == acc16_pkg::MODE_READ) begin
                        r_rd <= ram_rdata[IO-1:0];
                    end else begin
                        r_acc <= ram_rdata;
                    end
                    r_state <= S_DONE;
                end
                S_ALU: begin
                    if (alu_done) begin
                        r_alu   <= alu_result;
                        r_acc   <= alu_result;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_acc   <= r_acc[IO-1:0];
                        r_out_pc    <= r_pc;
                        r_out_rd    <= r_rd;
                        r_out_err   <= r_err;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Channel outputs.
    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.accumulator     = r_out_acc;
    assign o_out.program_counter = r_out_pc;
    assign o_out.read_word       = r_out_rd;
    assign o_out.error_code      = r_out_err;

    // Checks on the sequencer.
    `ACC16_ASSERT_NXT(a_accept_to_exec, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state == S_EXEC && !i_in.ready)
    `ACC16_ASSERT_IMP(a_alu_done_in_alu, i_clk, i_rst_n, alu_done, r_state == S_ALU)
    `ACC16_ASSERT_IMP(a_result_from_done, i_clk, i_rst_n, $rose(o_out.valid), $past(r_state == S_DONE))
    `ACC16_ASSERT_IMP(a_ram_write_state, i_clk, i_rst_n, ram_we, r_state == S_CLEAR || r_state == S_EXEC)

endmodule

FILE: design/acc16_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module acc16_ram #(
    parameter int  WIDTH = 16,
    parameter int  DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: design/acc16_alu.sv
// Shared iterative arithmetic unit: add in one step, shift-add multiply,
// restoring divide and modulo. Depends on acc16_pkg.
module acc16_alu #(
    parameter int WORD_BITS = acc16_pkg::WORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  acc16_pkg::t_alu_req                 i_req,
    input  logic [WORD_BITS-1:0]                i_a,
    input  logic [acc16_pkg::OPERAND_BITS-1:0]  i_b,
    output logic                                o_done,
    output logic [WORD_BITS-1:0]                o_result
);

    localparam int OB = acc16_pkg::OPERAND_BITS;
    localparam int CW = $clog2(WORD_BITS + 1);

    typedef enum logic {
        A_IDLE,
        A_RUN
    } t_state;

    t_state              r_state;
    acc16_pkg::t_alu_op  r_op;
    logic [CW-1:0]       r_cnt;
    logic [WORD_BITS-1:0] r_x;      // multiplicand, or dividend shifting into quotient
    logic [WORD_BITS-1:0] r_y;      // partial product
    logic [OB-1:0]       r_b;       // multiplier, or divisor
    logic [OB-1:0]       r_rem;     // partial remainder
    logic                r_done;
    logic [WORD_BITS-1:0] r_result;

    logic [WORD_BITS:0]   add_a;
    logic [WORD_BITS:0]   add_b;
    logic                 add_cin;
    logic [WORD_BITS:0]   add_sum;
    logic [OB:0]          rem_sh;
    logic                 no_borrow;
    logic [WORD_BITS-1:0] n_quo;
    logic [OB-1:0]        n_rem;
    logic [WORD_BITS-1:0] n_prod;

    // The one adder of the unit, steered by the operation in progress.
    always_comb begin
        rem_sh  = {r_rem, r_x[WORD_BITS-1]};
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        if (r_state == A_IDLE) begin
            add_a = {1'b0, i_a};
            add_b = (WORD_BITS+1)'(i_b);
        end else if (r_op == acc16_pkg::ALU_MUL) begin
            add_a = {1'b0, r_y};
            add_b = {1'b0, r_x};
        end else begin
            add_a   = (WORD_BITS+1)'(rem_sh);
            add_b   = ~((WORD_BITS+1)'(r_b));
            add_cin = 1'b1;
        end
        add_sum = add_a + add_b + (WORD_BITS+1)'(add_cin);
    end

    // Next values of one multiply or divide step.
    always_comb begin
        no_borrow = ~add_sum[WORD_BITS];
        n_quo     = {r_x[WORD_BITS-2:0], no_borrow};
        n_rem     = no_borrow ? add_sum[OB-1:0] : rem_sh[OB-1:0];
        n_prod    = r_b[0] ? add_sum[WORD_BITS-1:0] : r_y;
    end

    // Sequencer of the unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_op <= i_req.op;
                        r_x  <= i_a;
                        r_b  <= i_b;
                        unique case (i_req.op) inside
                            acc16_pkg::ALU_ADD: begin
                                r_result <= add_sum[WORD_BITS-1:0];
                                r_done   <= 1'b1;
                            end
                            acc16_pkg::ALU_MUL: begin
                                r_y     <= '0;
                                r_cnt   <= CW'(OB);
                                r_state <= A_RUN;
                            end
                            acc16_pkg::ALU_DIV, acc16_pkg::ALU_MOD: begin
                                r_rem   <= '0;
                                r_cnt   <= CW'(WORD_BITS);
                                r_state <= A_RUN;
                            end
                        endcase
                    end
                end
                A_RUN: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_op == acc16_pkg::ALU_MUL) begin
                        r_y <= n_prod;
                        r_x <= {r_x[WORD_BITS-2:0], 1'b0};
                        r_b <= {1'b0, r_b[OB-1:1]};
                        if (r_cnt == CW'(1)) begin
                            r_result <= n_prod;
                        end
                    end else begin
                        r_x   <= n_quo;
                        r_rem <= n_rem;
                        if (r_cnt == CW'(1)) begin
                            r_result <= (r_op == acc16_pkg::ALU_DIV) ? n_quo
                                                                   : WORD_BITS'(n_rem);
                        end
                    end
                    if (r_cnt == CW'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
